// ===== src/sml_pkg.sv =====
// sml_pkg: shared types and constants of the stress-majorization layout block
// used by sml_arith, sml_ram users and the top level; no dependencies
package sml_pkg;

  localparam int MAX_NODES   = 64;
  localparam int IDX_W       = 6;
  localparam int DADDR_W     = 2 * IDX_W;
  localparam int COORD_W     = 32;
  localparam int STRESS_W    = 63;

  localparam logic [1:0] KIND_DIST  = 2'd0;
  localparam logic [1:0] KIND_POS   = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_ITER_LIMIT = 2'd1;
  localparam logic [1:0] CFG_TOLERANCE  = 2'd2;

  localparam logic [6:0]  NODE_COUNT_RST = 7'd64;
  localparam logic [15:0] ITER_LIMIT_RST = 16'd1000;
  localparam logic [23:0] TOLERANCE_RST  = 24'd1678;

  localparam logic [63:0] TERM_CLAMP = 64'h0000_0100_0000_0000;
  localparam logic [STRESS_W-1:0] STRESS_MAX = {STRESS_W{1'b1}};

  typedef struct packed {
    logic start;
    logic sqrt_op;
  } sml_arith_req_t;

endpackage

// ===== src/sml_ram.sv =====
// sml_ram: generic single-write, single-read ram with registered read data
// no dependencies
module sml_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sml_arith.sv =====
// sml_arith: bit-serial 64/32 divider and 64-bit floor square root
// depends on sml_pkg for the request struct
module sml_arith import sml_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  sml_arith_req_t req,
  input  logic [63:0]    opa,
  input  logic [31:0]    opb,
  output logic           done,
  output logic [63:0]    result
);

  logic        busy_r, busy_nxt;
  logic        sqrt_r, sqrt_nxt;
  logic        done_r, done_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] sh_r, sh_nxt;
  logic [34:0] rem_r, rem_nxt;
  logic [63:0] res_r, res_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [34:0] rem_t;
  logic [34:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    sqrt_nxt = sqrt_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    dvs_nxt  = dvs_r;
    rem_t    = '0;
    trial    = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      sqrt_nxt = req.sqrt_op;
      cnt_nxt  = req.sqrt_op ? 7'd32 : 7'd64;
      sh_nxt   = opa;
      rem_nxt  = '0;
      res_nxt  = '0;
      dvs_nxt  = opb;
    end else if (busy_r) begin
      if (sqrt_r) begin
        rem_t = {rem_r[32:0], sh_r[63:62]};
        trial = {1'b0, res_r[31:0], 2'b01};
        sh_nxt = {sh_r[61:0], 2'b00};
        if (rem_t >= trial) begin
          rem_nxt = rem_t - trial;
          res_nxt = {res_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_t;
          res_nxt = {res_r[62:0], 1'b0};
        end
      end else begin
        rem_t = {2'b00, rem_r[31:0], sh_r[63]};
        trial = {3'b000, dvs_r};
        sh_nxt = {sh_r[62:0], 1'b0};
        if (rem_t >= trial) begin
          rem_nxt = rem_t - trial;
          res_nxt = {res_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_t;
          res_nxt = {res_r[62:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sqrt_r <= sqrt_nxt;
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== src/stress_majorization_layout.sv =====
// stress_majorization_layout: top level, sequencer, shared multiplier and stores
// depends on sml_pkg, sml_ram and sml_arith
// A distance load also writes the mirror entry, in state S_DWR2. A start item
// runs sweeps over the stored graph with one 32x32 multiplier and one
// bit-serial divide / square-root unit under a small sequencer; the block takes
// no input until all results are out. The square root of that unit takes 32
// steps and its divides 64; a run is one stress pass plus one sweep and one
// stress pass per iteration, then each result goes out through S_ORD, S_OCAP
// and S_OWAIT, which holds it while out_stall is high.
// Stores need no clearing pass after reset.
module stress_majorization_layout import sml_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [5:0]         in_row_index,
  input  logic [5:0]         in_col_index,
  input  logic [31:0]        in_target_distance,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_node_id,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [62:0]        out_final_stress,
  output logic [15:0]        out_sweeps_done,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_wdata
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DWR2  = 5'd1;
  localparam logic [4:0] S_RDI   = 5'd2;
  localparam logic [4:0] S_CAPI  = 5'd3;
  localparam logic [4:0] S_RDJ   = 5'd4;
  localparam logic [4:0] S_DXY   = 5'd5;
  localparam logic [4:0] S_MULX  = 5'd6;
  localparam logic [4:0] S_MULY  = 5'd7;
  localparam logic [4:0] S_SQRT  = 5'd8;
  localparam logic [4:0] S_SQW   = 5'd9;
  localparam logic [4:0] S_MULE  = 5'd10;
  localparam logic [4:0] S_MULDX = 5'd11;
  localparam logic [4:0] S_DIVX  = 5'd12;
  localparam logic [4:0] S_DIVXW = 5'd13;
  localparam logic [4:0] S_MULDY = 5'd14;
  localparam logic [4:0] S_DIVY  = 5'd15;
  localparam logic [4:0] S_DIVYW = 5'd16;
  localparam logic [4:0] S_NEXTJ = 5'd17;
  localparam logic [4:0] S_NDX   = 5'd18;
  localparam logic [4:0] S_NDXW  = 5'd19;
  localparam logic [4:0] S_NDY   = 5'd20;
  localparam logic [4:0] S_NDYW  = 5'd21;
  localparam logic [4:0] S_NWR   = 5'd22;
  localparam logic [4:0] S_PASSE = 5'd23;
  localparam logic [4:0] S_CONV1 = 5'd24;
  localparam logic [4:0] S_CONV2 = 5'd25;
  localparam logic [4:0] S_CONV3 = 5'd26;
  localparam logic [4:0] S_ORD   = 5'd27;
  localparam logic [4:0] S_OCAP  = 5'd28;
  localparam logic [4:0] S_OWAIT = 5'd29;

  logic [4:0]  state_r, state_nxt;
  logic [6:0]  node_count_r, node_count_nxt;
  logic [15:0] iter_limit_r, iter_limit_nxt;
  logic [23:0] tol_r, tol_nxt;
  logic [6:0]  n_r, n_nxt;
  logic [6:0]  i_r, i_nxt;
  logic [6:0]  j_r, j_nxt;
  logic        sweep_r, sweep_nxt;
  logic        first_r, first_nxt;
  logic [62:0] cur_r, cur_nxt;
  logic [62:0] prev_r, prev_nxt;
  logic [15:0] sc_r, sc_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [31:0] xi_r, xi_nxt, yi_r, yi_nxt, xj_r, xj_nxt, yj_r, yj_nxt;
  logic [31:0] ax_r, ax_nxt, ay_r, ay_nxt, d_r, d_nxt, dist_r, dist_nxt;
  logic        dxneg_r, dxneg_nxt, dyneg_r, dyneg_nxt;
  logic [63:0] sq_r, sq_nxt, num_r, num_nxt, sx_r, sx_nxt, sy_r, sy_nxt;
  logic [62:0] sacc_r, sacc_nxt;
  logic [31:0] newx_r, newx_nxt, newy_r, newy_nxt;
  logic [55:0] plo_r, plo_nxt;
  logic [54:0] phi_r, phi_nxt;
  logic [5:0]  ldrow_r, ldrow_nxt, ldcol_r, ldcol_nxt;
  logic [31:0] ldd_r, ldd_nxt;
  logic [5:0]  onode_r, onode_nxt;
  logic [31:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [62:0] ostress_r, ostress_nxt;
  logic [15:0] osweeps_r, osweeps_nxt;
  logic        olast_r, olast_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic                d_we;
  logic [DADDR_W-1:0]  d_waddr, d_raddr;
  logic [31:0]         d_wdata, d_rdata;
  logic                xy_we;
  logic [IDX_W-1:0]    xy_waddr, xy_raddr;
  logic [31:0]         x_wdata, y_wdata, x_rdata, y_rdata;

  sml_arith_req_t ar_req;
  logic [63:0]    ar_opa;
  logic [31:0]    ar_opb;
  logic           ar_done;
  logic [63:0]    ar_result;

  logic [32:0] dx, dy;
  logic [64:0] sum65;
  logic [31:0] e;
  logic [40:0] q41;
  logic [63:0] term;
  logic [87:0] lhs, rhs;
  logic        conv;
  logic [6:0]  jn;
  logic [6:0]  n_clamp;

  sml_ram #(.WIDTH(32), .DEPTH(MAX_NODES * MAX_NODES)) u_dist (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  sml_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_xram (
    .clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(x_wdata),
    .raddr(xy_raddr), .rdata(x_rdata)
  );

  sml_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_yram (
    .clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(y_wdata),
    .raddr(xy_raddr), .rdata(y_rdata)
  );

  sml_arith u_arith (
    .clk(clk), .rst_n(rst_n), .req(ar_req), .opa(ar_opa), .opb(ar_opb),
    .done(ar_done), .result(ar_result)
  );

  assign mul_p    = {32'd0, mul_a} * {32'd0, mul_b};
  assign d_raddr  = {i_r[5:0], j_r[5:0]};
  assign xy_raddr = (state_r == S_RDJ) ? j_r[5:0] : i_r[5:0];

  always_comb begin
    if (node_count_r < 7'd2) begin
      n_clamp = 7'd2;
    end else if (node_count_r > 7'(MAX_NODES)) begin
      n_clamp = 7'(MAX_NODES);
    end else begin
      n_clamp = node_count_r;
    end
  end

  // shared unit operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    e = (dist_r >= d_r) ? (dist_r - d_r) : (d_r - dist_r);
    case (state_r)
      S_MULX:  begin mul_a = ax_r; mul_b = ax_r; end
      S_MULY:  begin mul_a = ay_r; mul_b = ay_r; end
      S_MULE:  begin mul_a = e; mul_b = e; end
      S_MULDX: begin mul_a = d_r; mul_b = ax_r; end
      S_MULDY: begin mul_a = d_r; mul_b = ay_r; end
      S_CONV1: begin mul_a = prev_r[31:0]; mul_b = {8'd0, tol_r}; end
      S_CONV2: begin mul_a = {1'b0, prev_r[62:32]}; mul_b = {8'd0, tol_r}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    ar_req.start   = (state_r == S_SQRT) || (state_r == S_DIVX) || (state_r == S_DIVY) ||
                     (state_r == S_NDX) || (state_r == S_NDY);
    ar_req.sqrt_op = (state_r == S_SQRT);
    case (state_r)
      S_SQRT:  begin ar_opa = sq_r; ar_opb = '0; end
      S_DIVX:  begin ar_opa = num_r; ar_opb = dist_r; end
      S_DIVY:  begin ar_opa = num_r; ar_opb = dist_r; end
      S_NDX:   begin ar_opa = sx_r[63] ? (~sx_r + 64'd1) : sx_r; ar_opb = {25'd0, n_r - 7'd1}; end
      S_NDY:   begin ar_opa = sy_r[63] ? (~sy_r + 64'd1) : sy_r; ar_opb = {25'd0, n_r - 7'd1}; end
      default: begin ar_opa = '0; ar_opb = '0; end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    node_count_nxt = node_count_r;
    iter_limit_nxt = iter_limit_r;
    tol_nxt        = tol_r;
    n_nxt = n_r; i_nxt = i_r; j_nxt = j_r;
    sweep_nxt = sweep_r; first_nxt = first_r;
    cur_nxt = cur_r; prev_nxt = prev_r; sc_nxt = sc_r;
    out_valid_nxt = out_valid_r;
    xi_nxt = xi_r; yi_nxt = yi_r; xj_nxt = xj_r; yj_nxt = yj_r;
    ax_nxt = ax_r; ay_nxt = ay_r; d_nxt = d_r; dist_nxt = dist_r;
    dxneg_nxt = dxneg_r; dyneg_nxt = dyneg_r;
    sq_nxt = sq_r; num_nxt = num_r; sx_nxt = sx_r; sy_nxt = sy_r;
    sacc_nxt = sacc_r; newx_nxt = newx_r; newy_nxt = newy_r;
    plo_nxt = plo_r; phi_nxt = phi_r;
    ldrow_nxt = ldrow_r; ldcol_nxt = ldcol_r; ldd_nxt = ldd_r;
    onode_nxt = onode_r; ox_nxt = ox_r; oy_nxt = oy_r;
    ostress_nxt = ostress_r; osweeps_nxt = osweeps_r; olast_nxt = olast_r;
    d_we = 1'b0; d_waddr = {in_row_index, in_col_index}; d_wdata = in_target_distance;
    xy_we = 1'b0; xy_waddr = in_row_index; x_wdata = in_pos_x; y_wdata = in_pos_y;
    dx = {xi_r[31], xi_r} - {x_rdata[31], x_rdata};
    dy = {yi_r[31], yi_r} - {y_rdata[31], y_rdata};
    sum65 = '0;
    q41 = (ar_result > TERM_CLAMP) ? TERM_CLAMP[40:0] : ar_result[40:0];
    term = '0;
    lhs = {1'b0, (prev_r - cur_r), 24'd0};
    rhs = {phi_r, 32'd0} + {32'd0, plo_r};
    conv = (cur_r >= prev_r) || (lhs <= rhs);
    jn = j_r + 7'd1;
    if (sweep_r && (jn == i_r)) begin
      jn = j_r + 7'd2;
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT: node_count_nxt = cfg_wdata[6:0];
        CFG_ITER_LIMIT: iter_limit_nxt = cfg_wdata[15:0];
        CFG_TOLERANCE:  tol_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_DIST: begin
              d_we = 1'b1;
              ldrow_nxt = in_row_index;
              ldcol_nxt = in_col_index;
              ldd_nxt = in_target_distance;
              state_nxt = S_DWR2;
            end
            KIND_POS: xy_we = 1'b1;
            KIND_START: begin
              n_nxt = n_clamp;
              sc_nxt = '0;
              first_nxt = 1'b1;
              sweep_nxt = 1'b0;
              sacc_nxt = '0;
              i_nxt = 7'd0;
              j_nxt = 7'd1;
              state_nxt = S_RDI;
            end
            default: ;
          endcase
        end
      end
      S_DWR2: begin
        d_we = 1'b1;
        d_waddr = {ldcol_r, ldrow_r};
        d_wdata = ldd_r;
        state_nxt = S_IDLE;
      end
      S_RDI: begin
        sx_nxt = '0;
        sy_nxt = '0;
        state_nxt = S_CAPI;
      end
      S_CAPI: begin
        xi_nxt = x_rdata;
        yi_nxt = y_rdata;
        state_nxt = S_RDJ;
      end
      S_RDJ: state_nxt = S_DXY;
      S_DXY: begin
        xj_nxt = x_rdata;
        yj_nxt = y_rdata;
        d_nxt = d_rdata;
        dxneg_nxt = dx[32];
        dyneg_nxt = dy[32];
        ax_nxt = dx[32] ? 32'(~dx + 33'd1) : dx[31:0];
        ay_nxt = dy[32] ? 32'(~dy + 33'd1) : dy[31:0];
        state_nxt = S_MULX;
      end
      S_MULX: begin
        sq_nxt = mul_p;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        sum65 = {1'b0, sq_r} + {1'b0, mul_p};
        sq_nxt = sum65[64] ? {64{1'b1}} : sum65[63:0];
        state_nxt = S_SQRT;
      end
      S_SQRT: state_nxt = S_SQW;
      S_SQW: begin
        if (ar_done) begin
          dist_nxt = ar_result[31:0];
          if (!sweep_r) begin
            state_nxt = S_MULE;
          end else if (ar_result[31:0] == 32'd0) begin
            sx_nxt = sx_r + {{32{xj_r[31]}}, xj_r};
            sy_nxt = sy_r + {{32{yj_r[31]}}, yj_r};
            state_nxt = S_NEXTJ;
          end else begin
            state_nxt = S_MULDX;
          end
        end
      end
      S_MULE: begin
        sum65 = {2'b00, sacc_r} + {1'b0, mul_p};
        sacc_nxt = (sum65 > {2'b00, STRESS_MAX}) ? STRESS_MAX : sum65[62:0];
        state_nxt = S_NEXTJ;
      end
      S_MULDX: begin
        num_nxt = mul_p;
        state_nxt = S_DIVX;
      end
      S_DIVX: state_nxt = S_DIVXW;
      S_DIVXW: begin
        if (ar_done) begin
          term = dxneg_r ? (~{23'd0, q41} + 64'd1) : {23'd0, q41};
          sx_nxt = sx_r + {{32{xj_r[31]}}, xj_r} + term;
          state_nxt = S_MULDY;
        end
      end
      S_MULDY: begin
        num_nxt = mul_p;
        state_nxt = S_DIVY;
      end
      S_DIVY: state_nxt = S_DIVYW;
      S_DIVYW: begin
        if (ar_done) begin
          term = dyneg_r ? (~{23'd0, q41} + 64'd1) : {23'd0, q41};
          sy_nxt = sy_r + {{32{yj_r[31]}}, yj_r} + term;
          state_nxt = S_NEXTJ;
        end
      end
      S_NEXTJ: begin
        if (jn >= n_r) begin
          if (sweep_r) begin
            state_nxt = S_NDX;
          end else if (i_r + 7'd2 == n_r) begin
            state_nxt = S_PASSE;
          end else begin
            i_nxt = i_r + 7'd1;
            j_nxt = i_r + 7'd2;
            state_nxt = S_RDI;
          end
        end else begin
          j_nxt = jn;
          state_nxt = S_RDJ;
        end
      end
      S_NDX: state_nxt = S_NDXW;
      S_NDXW: begin
        if (ar_done) begin
          if (!sx_r[63]) begin
            newx_nxt = (ar_result > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : ar_result[31:0];
          end else begin
            newx_nxt = (ar_result > 64'h8000_0000) ? 32'h8000_0000
                                                     : (~ar_result[31:0] + 32'd1);
          end
          state_nxt = S_NDY;
        end
      end
      S_NDY: state_nxt = S_NDYW;
      S_NDYW: begin
        if (ar_done) begin
          if (!sy_r[63]) begin
            newy_nxt = (ar_result > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : ar_result[31:0];
          end else begin
            newy_nxt = (ar_result > 64'h8000_0000) ? 32'h8000_0000
                                                     : (~ar_result[31:0] + 32'd1);
          end
          state_nxt = S_NWR;
        end
      end
      S_NWR: begin
        xy_we = 1'b1;
        xy_waddr = i_r[5:0];
        x_wdata = newx_r;
        y_wdata = newy_r;
        if (i_r + 7'd1 == n_r) begin
          sweep_nxt = 1'b0;
          sacc_nxt = '0;
          i_nxt = 7'd0;
          j_nxt = 7'd1;
        end else begin
          i_nxt = i_r + 7'd1;
          j_nxt = 7'd0;
        end
        state_nxt = S_RDI;
      end
      S_PASSE: begin
        cur_nxt = sacc_r;
        if (first_r) begin
          first_nxt = 1'b0;
          sweep_nxt = 1'b1;
          i_nxt = 7'd0;
          j_nxt = 7'd1;
          state_nxt = S_RDI;
        end else begin
          prev_nxt = cur_r;
          sc_nxt = sc_r + 16'd1;
          state_nxt = S_CONV1;
        end
      end
      S_CONV1: begin
        plo_nxt = mul_p[55:0];
        state_nxt = S_CONV2;
      end
      S_CONV2: begin
        phi_nxt = mul_p[54:0];
        state_nxt = S_CONV3;
      end
      S_CONV3: begin
        i_nxt = 7'd0;
        if (!conv && (sc_r < iter_limit_r)) begin
          sweep_nxt = 1'b1;
          j_nxt = 7'd1;
          state_nxt = S_RDI;
        end else begin
          state_nxt = S_ORD;
        end
      end
      S_ORD: state_nxt = S_OCAP;
      S_OCAP: begin
        onode_nxt = i_r[5:0];
        ox_nxt = x_rdata;
        oy_nxt = y_rdata;
        ostress_nxt = cur_r;
        osweeps_nxt = sc_r;
        olast_nxt = (i_r + 7'd1 == n_r);
        out_valid_nxt = 1'b1;
        state_nxt = S_OWAIT;
      end
      S_OWAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (olast_r) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt = i_r + 7'd1;
            state_nxt = S_ORD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NODE_COUNT_RST;
      iter_limit_r <= ITER_LIMIT_RST;
      tol_r        <= TOLERANCE_RST;
      cur_r        <= '0;
      prev_r       <= '0;
      sc_r         <= '0;
      out_valid_r  <= 1'b0;
      n_r          <= 7'd2;
      i_r          <= '0;
      j_r          <= '0;
      sweep_r      <= 1'b0;
      first_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= node_count_nxt;
      iter_limit_r <= iter_limit_nxt;
      tol_r        <= tol_nxt;
      cur_r        <= cur_nxt;
      prev_r       <= prev_nxt;
      sc_r         <= sc_nxt;
      out_valid_r  <= out_valid_nxt;
      n_r          <= n_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      sweep_r      <= sweep_nxt;
      first_r      <= first_nxt;
    end
    xi_r <= xi_nxt; yi_r <= yi_nxt; xj_r <= xj_nxt; yj_r <= yj_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt; d_r <= d_nxt; dist_r <= dist_nxt;
    dxneg_r <= dxneg_nxt; dyneg_r <= dyneg_nxt;
    sq_r <= sq_nxt; num_r <= num_nxt; sx_r <= sx_nxt; sy_r <= sy_nxt;
    sacc_r <= sacc_nxt; newx_r <= newx_nxt; newy_r <= newy_nxt;
    plo_r <= plo_nxt; phi_r <= phi_nxt;
    ldrow_r <= ldrow_nxt; ldcol_r <= ldcol_nxt; ldd_r <= ldd_nxt;
    onode_r <= onode_nxt; ox_r <= ox_nxt; oy_r <= oy_nxt;
    ostress_r <= ostress_nxt; osweeps_r <= osweeps_nxt; olast_r <= olast_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_node_id      = onode_r;
  assign out_x            = ox_r;
  assign out_y            = oy_r;
  assign out_final_stress = ostress_r;
  assign out_sweeps_done  = osweeps_r;
  assign out_last         = olast_r;

endmodule

// ===== src/sml_checker.sv =====
// sml_checker: port-level assertions for the stress-majorization layout block
// bound to stress_majorization_layout; no other dependencies
module sml_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  out_node_id,
  input logic [15:0] out_sweeps_done,
  input logic        out_last
);

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> !out_valid)
    else $error("result after last transfer");

  a_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sweeps_done != 16'd0)
    else $error("result with no sweep done");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_node_id))
    else $error("stalled result changed");

endmodule

bind stress_majorization_layout sml_checker u_sml_checker (.*);
